/* rtl/core/sha1_message_digest_assert.svh */
// ----------------------------------------------------------------------------
// SHA-1 message digest assertion macros
// Concurrent property macros that check only in simulation. In synthesis
// builds they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define SHA1MD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha1 message digest assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SHA1MD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha1 message digest assertion failed");
`else
`define SHA1MD_ASSERT_SAME(label, ante, cons)
`define SHA1MD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared types, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   localparam int DIGEST_WORDS = 5;
   localparam int BLOCK_WORDS  = 16;

   typedef logic [31:0] word_type;

   localparam word_type INIT_VALUE [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type ROUND_CONST [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   localparam logic [7:0] PAD_MARK     = 8'h80;
   localparam logic [6:0] ROUND_LAST   = 7'd79;
   localparam logic [6:0] ROUND_GRP1   = 7'd20;
   localparam logic [6:0] ROUND_GRP2   = 7'd40;
   localparam logic [6:0] ROUND_GRP3   = 7'd60;
   localparam logic [5:0] POS_LAST     = 6'd63;
   localparam logic [5:0] POS_PRE_LEN  = 6'd55;
   localparam logic [2:0] WORD_LAST    = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_MSG,
      PH_MARK,
      PH_ZERO,
      PH_LEN,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      BS_DATA,
      BS_MARK,
      BS_ZERO,
      BS_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         put_en;
      byte_sel_type byte_sel;
      logic         count_en;
      logic         load_regs;
      logic         round_en;
      logic [1:0]   round_grp;
      logic         update_chain;
      logic         restart;
      logic [2:0]   word_index;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pos_pre_len;
   } dp_status_type;

endpackage

/* rtl/core/sha1md_datapath.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest datapath
// Block buffer with in-place message schedule, round registers, chaining
// value, byte position and bit count.
// ----------------------------------------------------------------------------
module sha1md_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  sha1md_pkg::ctrl_cmd_type   cmd,
   input  logic [7:0]                 data_byte,
   output sha1md_pkg::dp_status_type  status,
   output logic [31:0]                digest_word
);
   import sha1md_pkg::*;

   word_type    blk_ff   [BLOCK_WORDS];
   word_type    regs_ff  [DIGEST_WORDS];
   word_type    chain_ff [DIGEST_WORDS];
   logic [5:0]  pos_ff;
   logic [5:0]  pos_in;
   logic [63:0] cnt_ff;
   logic [63:0] cnt_in;

   logic [7:0]  put_byte;
   logic [63:0] len_shift;
   word_type    base_word;
   word_type    merged_word;
   word_type    sched_word;
   word_type    f_val;
   word_type    a_new;

   // Byte source for the buffer write.
   always_comb begin
      len_shift = cnt_ff >> {~pos_ff[2:0], 3'b000};
      case (cmd.byte_sel)
         BS_DATA: put_byte = data_byte;
         BS_MARK: put_byte = PAD_MARK;
         BS_ZERO: put_byte = 8'h00;
         BS_LEN:  put_byte = len_shift[7:0];
         default: put_byte = 8'h00;
      endcase
   end

   // A word is cleared when its first byte lands, so stale data never leaks.
   always_comb begin
      base_word   = (pos_ff[1:0] == 2'b00) ? '0 : blk_ff[pos_ff[5:2]];
      merged_word = base_word | ({24'h000000, put_byte} << {~pos_ff[1:0], 3'b000});
   end

   always_comb begin
      sched_word = blk_ff[13] ^ blk_ff[8] ^ blk_ff[2] ^ blk_ff[0];
      case (cmd.round_grp)
         2'd0:    f_val = (regs_ff[1] & regs_ff[2]) | (~regs_ff[1] & regs_ff[3]);
         2'd2:    f_val = (regs_ff[1] & regs_ff[2]) | (regs_ff[1] & regs_ff[3]) |
                          (regs_ff[2] & regs_ff[3]);
         default: f_val = regs_ff[1] ^ regs_ff[2] ^ regs_ff[3];
      endcase
      a_new = {regs_ff[0][26:0], regs_ff[0][31:27]} + f_val + regs_ff[4] +
              ROUND_CONST[cmd.round_grp] + blk_ff[0];
   end

   // Buffer: byte writes, or a shift by one word per round with the
   // expanded schedule word entering at the top.
   always_ff @(posedge clock) begin
      if (cmd.put_en) begin
         blk_ff[pos_ff[5:2]] <= merged_word;
      end else if (cmd.round_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            blk_ff[i] <= blk_ff[i + 1];
         end
         blk_ff[BLOCK_WORDS - 1] <= {sched_word[30:0], sched_word[31]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_regs) begin
         regs_ff <= chain_ff;
      end else if (cmd.round_en) begin
         regs_ff[0] <= a_new;
         regs_ff[1] <= regs_ff[0];
         regs_ff[2] <= {regs_ff[1][1:0], regs_ff[1][31:2]};
         regs_ff[3] <= regs_ff[2];
         regs_ff[4] <= regs_ff[3];
      end
   end

   always_comb begin
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (cmd.restart) begin
         pos_in = '0;
         cnt_in = '0;
      end else begin
         if (cmd.put_en) begin
            pos_in = pos_ff + 6'd1;
         end
         if (cmd.count_en) begin
            cnt_in = cnt_ff + 64'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_VALUE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         if (cmd.restart) begin
            chain_ff <= INIT_VALUE;
         end else if (cmd.update_chain) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_ff[i] <= chain_ff[i] + regs_ff[i];
            end
         end
      end
   end

   always_comb begin
      status.pos_last    = (pos_ff == POS_LAST);
      status.pos_pre_len = (pos_ff == POS_PRE_LEN);
      case (cmd.word_index)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         default: digest_word = chain_ff[4];
      endcase
   end

endmodule

/* rtl/core/sha1md_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest controller
// Sequences byte intake, padding, the 80 rounds and digest output.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_assert.svh"

module sha1md_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  sha1md_pkg::req_type        req_data,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  sha1md_pkg::dp_status_type  status,
   output sha1md_pkg::ctrl_cmd_type   cmd
);
   import sha1md_pkg::*;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [6:0] rnd_ff, rnd_in;
   logic [2:0] widx_ff, widx_in;
   logic       last_ff, last_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rnd_in   = rnd_ff;
      widx_in  = widx_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in  = req_data.is_last;
               phase_in = PH_MSG;
               if (req_data.has_byte && status.pos_last) begin
                  state_in = ST_ROUND;
                  rnd_in   = '0;
               end else if (req_data.is_last) begin
                  state_in = ST_PUT;
                  phase_in = PH_MARK;
               end
            end
         end
         ST_PUT: begin
            case (phase_ff)
               PH_MARK, PH_ZERO: phase_in = status.pos_pre_len ? PH_LEN : PH_ZERO;
               PH_LEN:           phase_in = status.pos_last ? PH_DONE : PH_LEN;
               default:          phase_in = phase_ff;
            endcase
            if (status.pos_last) begin
               state_in = ST_ROUND;
               rnd_in   = '0;
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            case (phase_ff)
               PH_MSG: begin
                  state_in = last_ff ? ST_PUT : ST_IDLE;
                  phase_in = last_ff ? PH_MARK : PH_MSG;
               end
               PH_DONE: begin
                  state_in = ST_EMIT;
                  widx_in  = '0;
               end
               default: state_in = ST_PUT;
            endcase
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (widx_ff == WORD_LAST) begin
                  state_in = ST_IDLE;
                  phase_in = PH_MSG;
                  last_in  = 1'b0;
               end else begin
                  widx_in = widx_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      rsp_valid      = (state_ff == ST_EMIT);
      cmd            = '0;
      cmd.byte_sel   = BS_DATA;
      cmd.word_index = widx_ff;
      if (rnd_ff < ROUND_GRP1) begin
         cmd.round_grp = 2'd0;
      end else if (rnd_ff < ROUND_GRP2) begin
         cmd.round_grp = 2'd1;
      end else if (rnd_ff < ROUND_GRP3) begin
         cmd.round_grp = 2'd2;
      end else begin
         cmd.round_grp = 2'd3;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.has_byte) begin
               cmd.put_en    = 1'b1;
               cmd.count_en  = 1'b1;
               cmd.load_regs = status.pos_last;
            end
         end
         ST_PUT: begin
            cmd.put_en    = 1'b1;
            cmd.load_regs = status.pos_last;
            case (phase_ff)
               PH_MARK: cmd.byte_sel = BS_MARK;
               PH_LEN:  cmd.byte_sel = BS_LEN;
               default: cmd.byte_sel = BS_ZERO;
            endcase
         end
         ST_ROUND:  cmd.round_en = 1'b1;
         ST_UPDATE: cmd.update_chain = 1'b1;
         ST_EMIT:   cmd.restart = !rsp_stall && (widx_ff == WORD_LAST);
         default:   cmd = cmd;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MSG;
         rnd_ff   <= '0;
         widx_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rnd_ff   <= rnd_in;
         widx_ff  <= widx_in;
         last_ff  <= last_in;
      end
   end

   `SHA1MD_ASSERT_NEXT(a_round_end, state_ff == ST_ROUND && rnd_ff == ROUND_LAST, state_ff == ST_UPDATE)
   `SHA1MD_ASSERT_NEXT(a_len_done, state_ff == ST_PUT && phase_ff == PH_LEN && status.pos_last, phase_ff == PH_DONE && state_ff == ST_ROUND)
   `SHA1MD_ASSERT_NEXT(a_emit_end, cmd.restart, state_ff == ST_IDLE && widx_ff == WORD_LAST)
   `SHA1MD_ASSERT_SAME(a_put_excl, cmd.put_en, !cmd.round_en && !cmd.update_chain)

endmodule

/* rtl/core/sha1_message_digest.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Hashes a byte stream into a 160-bit digest, one byte per input item.
// ----------------------------------------------------------------------------
// The request channel takes one message byte per item; has_byte marks a real
// byte and is_last ends the message. An empty last item hashes what has come
// so far, which is the empty-message digest when nothing came before.
// A byte that does not complete a 64-byte block is written into the block
// buffer. The byte that completes a block starts the compression, which
// runs one round per cycle on a single shared round unit; req_stall is
// high meanwhile, so no new byte is taken until it is done.
// The last item triggers padding, written one byte per cycle into the block
// buffer, and one or two more compressions before the first digest word
// appears.
// The response channel then carries five items, digest word 0 first, and
// last_word set on word 4. While the receiver stalls, the word on offer
// holds and the block waits. After word 4 is taken the chaining value,
// byte position and bit count return to their initial values and req_stall
// drops again.
// Reset is synchronous and active high. It restores the initial chaining
// value and clears the position and length, with no clearing pass.
// ----------------------------------------------------------------------------
module sha1_message_digest (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sha1md_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sha1md_pkg::rsp_type  rsp_data
);
   import sha1md_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [31:0]   digest_word;

   // The controller owns all sequencing; the datapath only follows commands.
   sha1md_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic: block buffer, rounds, chaining value, length.
   sha1md_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data.data_byte),
      .status      (status),
      .digest_word (digest_word)
   );

   // The word index comes from a register in the controller, so the whole
   // response stays put while the receiver stalls.
   always_comb begin
      rsp_data.digest_word = digest_word;
      rsp_data.word_index  = cmd.word_index;
      rsp_data.last_word   = (cmd.word_index == WORD_LAST);
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams messages one byte per item into the hasher, works out each digest
// with a bit-accurate software hash kept in step with every accepted item,
// and checks the five digest words of every message in order.
// ----------------------------------------------------------------------------
module tb_top;
   import sha1md_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 300;
   localparam int LONG_HOLD = 500;
   localparam logic [5:0] LEN_FIELD_POS = 6'd56;

   // One queued item for the sender. A set pause flag makes the sender wait
   // until every digest word still owed has come back before it offers the
   // item.
   typedef struct {
      req_type item;
      bit      pause;
   } stim_entry_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sha1_message_digest uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   stim_entry_type pending_items[$];
   rsp_type        digest_words_due[$];

   // Software copy of the hashing state: chaining value, the 16-word block
   // being filled, the byte slot within it and the message length in bits.
   word_type    hash_state [DIGEST_WORDS];
   logic [31:0] msg_block [BLOCK_WORDS];
   logic [5:0]  fill_pos;
   logic [63:0] bit_len;

   int   fail_count = 0;
   int   items_taken = 0;
   int   cycle_count = 0;
   logic req_fire;

   // ------------------------------------------------------------------------
   // Software SHA-1
   // ------------------------------------------------------------------------

   task automatic restart_hash();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         hash_state[i] = INIT_VALUE[i];
      end
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         msg_block[i] = '0;
      end
      fill_pos = '0;
      bit_len = '0;
   endtask

   // Standard 80-round compression of msg_block into hash_state.
   task automatic compress_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      for (int t = 0; t < 16; t++) begin
         sched[t] = msg_block[t];
      end
      for (int t = 16; t < 80; t++) begin
         tmp = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
         sched[t] = {tmp[30:0], tmp[31]};
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = ROUND_CONST[0];
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = ROUND_CONST[1];
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = ROUND_CONST[2];
         end else begin
            f = b ^ c ^ d;
            k = ROUND_CONST[3];
         end
         tmp = {a[26:0], a[31:27]} + f + e + k + sched[t];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = tmp;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endtask

   // Bytes pack big-endian into the block words; a word is cleared when its
   // first byte lands, and the block is compressed as soon as it is full.
   task automatic absorb_byte(input logic [7:0] b);
      logic [3:0] idx;
      idx = fill_pos[5:2];
      if (fill_pos[1:0] == 2'd0) begin
         msg_block[idx] = '0;
      end
      msg_block[idx][8 * (3 - fill_pos[1:0]) +: 8] = b;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) begin
         compress_block();
      end
   endtask

   // Applies one accepted item. A last item pads the message (marker byte,
   // zeros up to the length field, 64-bit bit count), which may spill into a
   // second block, then queues the five digest words and starts afresh.
   task automatic hash_item(input req_type r);
      logic [63:0] total_bits;
      rsp_type     word;
      if (r.has_byte) begin
         bit_len = bit_len + 64'd8;
         absorb_byte(r.data_byte);
      end
      if (r.is_last) begin
         total_bits = bit_len;
         absorb_byte(PAD_MARK);
         while (fill_pos != LEN_FIELD_POS) begin
            absorb_byte(8'h00);
         end
         for (int i = 7; i >= 0; i--) begin
            absorb_byte(total_bits[8 * i +: 8]);
         end
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            word.digest_word = hash_state[i];
            word.word_index = i[2:0];
            word.last_word = (i[2:0] == WORD_LAST);
            digest_words_due.push_back(word);
         end
         restart_hash();
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------

   task automatic add_item(input logic [7:0] data, input logic has, input logic last,
                           input bit pause);
      stim_entry_type s;
      s.item.data_byte = data;
      s.item.has_byte = has;
      s.item.is_last = last;
      s.pause = pause;
      pending_items.push_back(s);
   endtask

   // A well-formed message of random bytes, with the odd idle item mixed in.
   // The end flag rides on the final byte about half the time; otherwise an
   // empty last item closes the message.
   task automatic add_message(input int len, input bit pause);
      bit fold_last;
      bit first;
      fold_last = (len > 0) && ($urandom_range(0, 1) == 1);
      first = 1'b1;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, pause && first);
            first = 1'b0;
         end
         add_item(8'($urandom_range(0, 255)), 1'b1, fold_last && (i == len - 1),
                  pause && first);
         first = 1'b0;
      end
      if (!fold_last) begin
         add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, pause && first);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence: reset, stimulus, drain, verdict
   // ------------------------------------------------------------------------

   initial begin
      int rand_start;
      int len;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      req_fire = 1'b0;
      restart_hash();

      // Directed part. The empty message comes first, straight out of reset.
      add_item(8'h00, 1'b0, 1'b1, 1'b0);
      // An idle item must change nothing, whatever its data.
      add_item(8'hFF, 1'b0, 1'b0, 1'b0);
      // "abc" with the end flag on its final byte.
      add_item(8'h61, 1'b1, 1'b0, 1'b0);
      add_item(8'h62, 1'b1, 1'b0, 1'b0);
      add_item(8'h63, 1'b1, 1'b1, 1'b0);
      // Extreme byte values, closed by an empty last item with junk data.
      add_item(8'h00, 1'b1, 1'b0, 1'b0);
      add_item(8'hFF, 1'b1, 1'b0, 1'b0);
      add_item(8'h80, 1'b1, 1'b0, 1'b0);
      add_item(8'hFF, 1'b0, 1'b1, 1'b0);
      // A single 0xFF byte that is also the last item.
      add_item(8'hFF, 1'b1, 1'b1, 1'b0);
      // A second empty message after a non-empty one, offered only once the
      // hasher has fully drained.
      add_item(8'h5A, 1'b0, 1'b1, 1'b1);

      // Random part. The first message holds one full block plus 56 bytes,
      // so a block is compressed mid-message and the padding needs two more.
      // Short messages top up the stream when the first one ran short.
      rand_start = pending_items.size();
      add_message(120, 1'b1);
      while (pending_items.size() - rand_start < 130) begin
         len = $urandom_range(0, 14);
         add_message(len, $urandom_range(0, 5) == 0);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (digest_words_due.size() != 0) begin
         @(posedge clock);
      end
      // Anything that shows up now is an unexpected word.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sender: bursts of random length separated by random gaps. An item on
   // offer holds until it is taken; req_fire tells whether the item shown
   // was accepted at the last rising edge.
   // ------------------------------------------------------------------------

   int             burst_left = 0;
   int             gap_left = 0;
   stim_entry_type next_entry;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_items[0].pause && digest_words_due.size() != 0) begin
            // Hold back until the hasher has handed over every owed word.
            req_valid <= 1'b0;
         end else begin
            next_entry = pending_items.pop_front();
            req_data <= next_entry.item;
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall pattern that switches between no stall, light and heavy
   // random stall, and a strict toggle. Once, with a digest pending after forty
   // items have been taken, it holds off for a long stretch so the hasher backs
   // up and stalls its input.
   // ------------------------------------------------------------------------

   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && items_taken >= 40 && digest_words_due.size() != 0) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ~rsp_stall;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: hashes each accepted item and checks each accepted digest word
   // against the oldest one owed.
   // ------------------------------------------------------------------------

   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            items_taken++;
            hash_item(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_words_due.size() == 0) begin
               $display("%0t: unexpected digest word %h index %0d last %b", $time,
                        rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
               fail_count++;
            end else begin
               want = digest_words_due.pop_front();
               if (rsp_data.digest_word !== want.digest_word) begin
                  $display("%0t: digest_word expected %h got %h", $time,
                           want.digest_word, rsp_data.digest_word);
                  fail_count++;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $display("%0t: word_index expected %0d got %0d", $time,
                           want.word_index, rsp_data.word_index);
                  fail_count++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $display("%0t: last_word expected %b got %b", $time,
                           want.last_word, rsp_data.last_word);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule
